// ----- design/e2r_pkg.sv -----
// shared constants, types and helpers for the euler to rotation matrix unit
package e2r_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int NSTEP        = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int HALF_PI_Q13  = 12868;
    localparam int PI_Q13       = 25736;
    localparam int ONE_Q14      = 16384;

    // cordic datapath: q30 values stay well inside 34 bits signed
    localparam int CW = 34;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [15:0] t_q14;

    typedef struct packed {
        t_cw x;
        t_cw y;
        t_cw z;
        logic flip;
    } t_cell;

    function automatic t_cw atan_q30(input logic [4:0] i);
        t_cw v;
        case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp a wide signed value to +-1.0 in q1.14
    function automatic t_q14 clamp_unit(input logic signed [47:0] v);
        t_q14 r;
        if (v > 48'sd16384) begin
            r = 16'sd16384;
        end else if (v < -48'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- design/e2r_cordic_cell.sv -----
// one rotation-mode cordic iteration for the three angles, registered
module e2r_cordic_cell
    import e2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_step,
    input  t_cell      i_cell [3],
    output t_cell      o_cell [3]
);

    t_cell n_cell [3];
    t_cell r_cell [3];

    // i_step is tied to a constant per cell, so the shifts reduce to wiring
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cell[k].flip = i_cell[k].flip;
            if (!i_cell[k].z[CW-1]) begin
                n_cell[k].x = i_cell[k].x - (i_cell[k].y >>> i_step);
                n_cell[k].y = i_cell[k].y + (i_cell[k].x >>> i_step);
                n_cell[k].z = i_cell[k].z - atan_q30(i_step);
            end else begin
                n_cell[k].x = i_cell[k].x + (i_cell[k].y >>> i_step);
                n_cell[k].y = i_cell[k].y - (i_cell[k].x >>> i_step);
                n_cell[k].z = i_cell[k].z + atan_q30(i_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ----- design/e2r_matrix.sv -----
// rotation entries from the sines and cosines, two registered product stages
module e2r_matrix
    import e2r_pkg::*;
(
    input  logic i_clk,
    input  logic i_en0,
    input  logic i_en1,
    input  t_q14 i_sr,
    input  t_q14 i_cr,
    input  t_q14 i_sp,
    input  t_q14 i_cp,
    input  t_q14 i_sy,
    input  t_q14 i_cy,
    output t_q14 o_m [9]
);

    // stage one: all two-factor products, q28
    logic signed [31:0] r_crcy, r_crsy, r_srcy, r_srsy, r_spsy, r_spcy;
    logic signed [31:0] r_srcp, r_crcp, r_cpsy, r_cpcy;
    t_q14 r_sr, r_cr, r_sp;
    // stage two: three-factor terms in q42
    logic signed [47:0] n_a0, n_a1, n_a3, n_a4;

    always_ff @(posedge i_clk) begin
        if (i_en0) begin
            r_crcy <= i_cr * i_cy;
            r_crsy <= i_cr * i_sy;
            r_srcy <= i_sr * i_cy;
            r_srsy <= i_sr * i_sy;
            r_spsy <= i_sp * i_sy;
            r_spcy <= i_sp * i_cy;
            r_srcp <= i_sr * i_cp;
            r_crcp <= i_cr * i_cp;
            r_cpsy <= i_cp * i_sy;
            r_cpcy <= i_cp * i_cy;
            r_sr   <= i_sr;
            r_cr   <= i_cr;
            r_sp   <= i_sp;
        end
    end

    always_comb begin
        n_a0 = (48'(r_crcy) <<< 14) + 48'(r_sr) * 48'(r_spsy);
        n_a1 = -(48'(r_crsy) <<< 14) + 48'(r_sr) * 48'(r_spcy);
        n_a3 = (48'(r_srcy) <<< 14) - 48'(r_cr) * 48'(r_spsy);
        n_a4 = -(48'(r_srsy) <<< 14) - 48'(r_cr) * 48'(r_spcy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            o_m[0] <= clamp_unit((n_a0 + 48'sd134217728) >>> 28);
            o_m[1] <= clamp_unit((n_a1 + 48'sd134217728) >>> 28);
            o_m[2] <= clamp_unit((48'(r_srcp) + 48'sd8192) >>> 14);
            o_m[3] <= clamp_unit((n_a3 + 48'sd134217728) >>> 28);
            o_m[4] <= clamp_unit((n_a4 + 48'sd134217728) >>> 28);
            o_m[5] <= clamp_unit((-48'(r_crcp) + 48'sd8192) >>> 14);
            o_m[6] <= clamp_unit((48'(r_cpsy) + 48'sd8192) >>> 14);
            o_m[7] <= clamp_unit((48'(r_cpcy) + 48'sd8192) >>> 14);
            o_m[8] <= clamp_unit(-48'(r_sp));
        end
    end

endmodule

// ----- design/euler_to_rotation_matrix_unit.sv -----
// top level: angle fold, chain of cordic cells, product stages, output
// channel  | signals                                     | direction
// in       | i_valid/o_ready, angles and positions       | input beat
// out      | o_valid/i_ready, m00..m22 and trans_x..z     | output beat
// one pose per cycle while the output beat is not stalled; stages in order: fold,
// NSTEP cordic cells, trig rounding, products, three-factor sums
// the whole pipeline advances together; it holds when the output beat stalls
// reset clears the stage valid bits only; payload stages carry no reset
module euler_to_rotation_matrix_unit
    import e2r_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22,
    output logic signed [31:0] o_trans_x,
    output logic signed [31:0] o_trans_y,
    output logic signed [31:0] o_trans_z
);

    localparam int DEPTH = NSTEP + 4;

    logic               adv;
    logic [DEPTH-1:0]   r_vld;
    logic signed [31:0] r_pos [DEPTH][3];
    t_cell              chain [NSTEP+1][3];
    t_cell              r_fold [3];
    t_q14               r_sin [3];
    t_q14               r_cos [3];
    t_q14               w_m [9];
    logic signed [15:0] w_ang [3];

    // stall only when the last stage holds a beat nobody takes
    assign adv     = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pos[0][0] <= i_pos_x;
            r_pos[0][1] <= i_pos_y;
            r_pos[0][2] <= i_pos_z;
            for (int s = 1; s < DEPTH; s++) begin
                r_pos[s] <= r_pos[s-1];
            end
        end
    end

    assign w_ang[0] = i_roll_angle;
    assign w_ang[1] = i_pitch_angle;
    assign w_ang[2] = i_yaw_angle;

    // fold into +-pi/2, remember to negate afterwards
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_fold[k].x <= GAIN_Q30;
                r_fold[k].y <= '0;
                if (w_ang[k] > 16'sd12868) begin
                    r_fold[k].z    <= CW'(w_ang[k] - 17'sd25736) <<< 17;
                    r_fold[k].flip <= 1'b1;
                end else if (w_ang[k] < -16'sd12868) begin
                    r_fold[k].z    <= CW'(w_ang[k] + 17'sd25736) <<< 17;
                    r_fold[k].flip <= 1'b1;
                end else begin
                    r_fold[k].z    <= CW'(w_ang[k]) <<< 17;
                    r_fold[k].flip <= 1'b0;
                end
            end
        end
    end

    assign chain[0] = r_fold;

    for (genvar g = 0; g < NSTEP; g++) begin : g_cell
        e2r_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_step (5'(g)),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    // round to q1.14, clamp, undo the fold
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                if (chain[NSTEP][k].flip) begin
                    r_sin[k] <= -clamp_unit(48'((chain[NSTEP][k].y + 34'sd32768) >>> 16));
                    r_cos[k] <= -clamp_unit(48'((chain[NSTEP][k].x + 34'sd32768) >>> 16));
                end else begin
                    r_sin[k] <= clamp_unit(48'((chain[NSTEP][k].y + 34'sd32768) >>> 16));
                    r_cos[k] <= clamp_unit(48'((chain[NSTEP][k].x + 34'sd32768) >>> 16));
                end
            end
        end
    end

    e2r_matrix u_matrix (
        .i_clk (i_clk),
        .i_en0 (adv),
        .i_en1 (adv),
        .i_sr  (r_sin[0]),
        .i_cr  (r_cos[0]),
        .i_sp  (r_sin[1]),
        .i_cp  (r_cos[1]),
        .i_sy  (r_sin[2]),
        .i_cy  (r_cos[2]),
        .o_m   (w_m)
    );

    assign o_m00 = w_m[0];
    assign o_m01 = w_m[1];
    assign o_m02 = w_m[2];
    assign o_m10 = w_m[3];
    assign o_m11 = w_m[4];
    assign o_m12 = w_m[5];
    assign o_m20 = w_m[6];
    assign o_m21 = w_m[7];
    assign o_m22 = w_m[8];
    assign o_trans_x = r_pos[DEPTH-1][0];
    assign o_trans_y = r_pos[DEPTH-1][1];
    assign o_trans_z = r_pos[DEPTH-1][2];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_trans_x) && $stable(o_m00))
        else $error("output beat changed under stall");
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output stage");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_m22 <= 16'sd16384) && (o_m22 >= -16'sd16384))
        else $error("entry out of unit range");

endmodule

// ----- dv/tb_top.sv -----
// testbench for the euler to rotation matrix unit: random and directed poses checked per beat
module tb_top
    import e2r_pkg::*;
;

    localparam int LATENCY     = NSTEP + 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] m [9];
        logic signed [31:0] t [3];
    } t_pose_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_roll_angle, i_pitch_angle, i_yaw_angle;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;
    logic signed [31:0] o_trans_x, o_trans_y, o_trans_z;

    t_pose_result expected_poses[$];
    int           error_count;
    int           cycle_count;
    bit           stall_heavy;

    euler_to_rotation_matrix_unit u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor shift of a signed 64 bit value
    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > ONE_Q14) return ONE_Q14;
        if (v < -ONE_Q14) return -ONE_Q14;
        return v;
    endfunction

    function automatic void angle_sincos(logic signed [15:0] ang, output longint s,
                                         output longint c);
        longint a, x, y, z, dx, dy;
        bit     flip;
        a = ang;
        flip = 1'b0;
        if (a > HALF_PI_Q13) begin
            a -= PI_Q13;
            flip = 1'b1;
        end else if (a < -HALF_PI_Q13) begin
            a += PI_Q13;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = a * 131072;
        for (int i = 0; i < NSTEP; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
            end else begin
                x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
            end
        end
        c = unit_clamp(floor_shift(x + 32768, 16));
        s = unit_clamp(floor_shift(y + 32768, 16));
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic longint round_triple(longint v);
        return unit_clamp(floor_shift(v + 134217728, 28));
    endfunction

    function automatic longint round_pair(longint v);
        return unit_clamp(floor_shift(v + 8192, 14));
    endfunction

    function automatic t_pose_result pose_transform(logic signed [15:0] r, p, yw,
                                                    logic signed [31:0] px, py, pz);
        t_pose_result res;
        longint sr, cr, sp, cp, sy, cy;
        angle_sincos(r, sr, cr);
        angle_sincos(p, sp, cp);
        angle_sincos(yw, sy, cy);
        res.m[0] = 16'(round_triple(cr * cy * ONE_Q14 + sr * (sp * sy)));
        res.m[1] = 16'(round_triple(-cr * sy * ONE_Q14 + sr * (sp * cy)));
        res.m[2] = 16'(round_pair(sr * cp));
        res.m[3] = 16'(round_triple(sr * cy * ONE_Q14 - cr * (sp * sy)));
        res.m[4] = 16'(round_triple(-sr * sy * ONE_Q14 - cr * (sp * cy)));
        res.m[5] = 16'(round_pair(-cr * cp));
        res.m[6] = 16'(round_pair(cp * sy));
        res.m[7] = 16'(round_pair(cp * cy));
        res.m[8] = 16'(unit_clamp(-sp));
        res.t[0] = px;
        res.t[1] = py;
        res.t[2] = pz;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // valid drops only when a gap follows, so back-to-back beats keep it high
    task automatic send_pose(logic signed [15:0] r, p, yw, logic signed [31:0] px, py, pz,
                             bit with_gaps = 1'b1);
        int gap;
        gap = with_gaps ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_roll_angle  <= r;
        i_pitch_angle <= p;
        i_yaw_angle   <= yw;
        i_pos_x       <= px;
        i_pos_y       <= py;
        i_pos_z       <= pz;
        do @(posedge i_clk); while (!o_ready);
        expected_poses.push_back(pose_transform(r, p, yw, px, py, pz));
    endtask

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 200)) - 100 + HALF_PI_Q13);
            2: return 16'(-$signed($urandom_range(0, 200)) + 100 - HALF_PI_Q13);
            default: return 16'($signed($urandom_range(0, 2 * PI_Q13)) - PI_Q13);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] edges[] = '{16'sd0, 16'sd12868, -16'sd12868, 16'sd12869,
                                        -16'sd12869, 16'sd25736, -16'sd25736, 16'sh7fff,
                                        16'sh8000, 16'sd6434, -16'sd1};
        foreach (edges[k]) begin
            send_pose(edges[k], 16'sd0, 16'sd0, 32'sh7fffffff, 32'sh80000000, 32'sd0);
            send_pose(16'sd0, edges[k], edges[(k + 3) % edges.size()], 32'sd0,
                      32'shffffffff, 32'sh55555555);
        end
        send_pose(16'sd25736, 16'sd25736, 16'sd25736, 32'shaaaaaaaa, 32'sd1, 32'sd0, 1'b0);
        send_pose(16'sd12868, -16'sd12868, 16'sd12868, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            send_pose(random_angle(), random_angle(), random_angle(), $urandom, $urandom,
                      $urandom, n % 300 > 60);
        end
    endtask

    // beats, back-to-back at first and then with gaps, under a mostly stalled receiver
    task automatic test_backpressure(int count);
        stall_heavy = 1'b1;
        test_random(count);
        wait_drained();
        stall_heavy = 1'b0;
    endtask

    // receiver side: random stalls, checks each accepted beat
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (stall_heavy) i_ready <= ($urandom_range(0, 3) == 0);
                else if ($urandom_range(0, 40) == 0) i_ready <= 1'b0;
                else if ((cycle_count / 500) % 3 == 0) i_ready <= 1'b1;
                else i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pose_result want;
        logic signed [15:0] got_m[9];
        logic signed [31:0] got_t[3];
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            got_m = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            got_t = '{o_trans_x, o_trans_y, o_trans_z};
            if (expected_poses.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                want = expected_poses.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got_m[k] !== want.m[k])
                        report_mismatch($sformatf("m%0d%0d", k / 3, k % 3), got_m[k], want.m[k]);
                for (int k = 0; k < 3; k++)
                    if (got_t[k] !== want.t[k])
                        report_mismatch($sformatf("trans%0d", k), got_t[k], want.t[k]);
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("euler_to_rotation_matrix_unit verification failed");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        stall_heavy   = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_roll_angle  = '0;
        i_pitch_angle = '0;
        i_yaw_angle   = '0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pos_z       = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(700);
        wait_drained();
        test_backpressure(150);
        test_random(580);
        wait_drained();
        if (error_count == 0) begin
            $display("euler_to_rotation_matrix_unit verification clean");
        end else begin
            $display("euler_to_rotation_matrix_unit verification failed");
        end
        $finish;
    end

endmodule
